FILE: hdl/lru_key_value_cache_assert.svh
// assertion macros for the lru key-value cache
// used by lru_key_value_cache.sv, expects clk and rst in scope
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define LKV_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define LKV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LKV_ASSERT_ALWAYS(label, expr, msg)
`define LKV_ASSERT_IMPL(label, ante, cons, msg)
`define LKV_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/lkv_pkg.sv
// shared types and constants for the lru key-value cache
// no dependencies
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] PUT_VALUE  = 32'h0000_0000;

  // update broadcast to every entry
  typedef struct packed {
    logic             touch;
    logic             wr_key;
    logic             wr_val;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_cmd_t;

endpackage

FILE: hdl/lkv_entry.sv
// one entry of the cache: key compare, stored value and recency rank
// depends on lkv_pkg
`timescale 1ns / 1ps
module lkv_entry
  import lkv_pkg::*;
#(
  parameter int RANK_W = 4,
  parameter int THR_W  = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  lkv_cmd_t          cmd,
  input  logic              sel,
  input  logic [THR_W-1:0]  thresh,
  output logic              match,
  output logic              valid,
  output logic [RANK_W-1:0] rank,
  output logic [VAL_W-1:0]  value
);

  logic [KEY_W-1:0] key;

  assign match = valid && (key == cmd.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.touch) begin
      if (sel) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (valid && (THR_W'(rank) < thresh)) begin
        // more recent than the touched entry, ages by one
        rank <= rank + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.touch && sel && cmd.wr_key) begin
      key <= cmd.key;
    end
    if (cmd.touch && sel && cmd.wr_val) begin
      value <= cmd.value;
    end
  end

endmodule

FILE: hdl/lru_key_value_cache.sv
// top level of the fully associative lru key-value cache
// depends on lkv_pkg, lkv_entry and lru_key_value_cache_assert.svh
//
// usage
//   input channel in_valid / in_ready carries one item: action (0 get, 1 put),
//   lookup_key and write_value. output channel out_valid / out_ready carries
//   one result item per input item: hit and read_value.
//   cfg_wr_en / cfg_wr_data write the capacity register; write only while idle.
// pipeline and throughput
//   an accepted item is held in the input register, where all entries compare
//   in parallel and ranks update; its result is then written to the output
//   register, which raises out_valid, unless a held result stalls it there.
//   one item per cycle sustained while out_ready stays high, as the key compare
//   and rank update across the entry array are done in the input register stage.
// reset
//   synchronous rst clears all entry valid marks, ranks and occupancy, and sets
//   capacity to 16; stored keys and values are left as they were.
// stalls
//   while out_ready is low a held result blocks the input register; in_ready
//   drops only once both the input register and the output register are full.
`timescale 1ns / 1ps
`include "lru_key_value_cache_assert.svh"
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CAP_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    action,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] write_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value
);

  // rank holds 0..DEPTH-1, occupancy and thresholds hold 0..DEPTH
  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  // configuration
  logic [CAP_W-1:0] capacity;
  logic [OW-1:0]    eff_cap;

  // input register
  logic             s1_v;
  logic             s1_action;
  logic [KEY_W-1:0] s1_key;
  logic [VAL_W-1:0] s1_val;

  // cache state outside the entries
  logic [OW-1:0] occupancy;

  // entry array
  lkv_cmd_t        cmd;
  logic [DEPTH-1:0] target;
  logic [OW-1:0]    thresh;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] victim;
  logic [DEPTH-1:0] free_slot;
  logic [RW-1:0]    rank  [DEPTH];
  logic [VAL_W-1:0] value [DEPTH];

  // lookup result
  logic          proc;
  logic          found;
  logic          is_put;
  logic          full;
  logic          insert;
  logic [OW-1:0] occ_m1;
  logic [RW-1:0]    hit_rank;
  logic [VAL_W-1:0] hit_val;
  logic [VAL_W-1:0] res_val;

  // capacity register, zero means one and anything above the array saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_comb begin
    if (32'(capacity) > DEPTH) begin
      eff_cap = OW'(DEPTH);
    end else if (capacity == '0) begin
      eff_cap = OW'(1);
    end else begin
      eff_cap = OW'(capacity);
    end
  end

  // handshake: the input register drains whenever the result register can take
  assign proc     = s1_v && (!out_valid || out_ready);
  assign in_ready = !s1_v || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_ready) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_key    <= $unsigned(lookup_key);
      s1_val    <= $unsigned(write_value);
    end
  end

  // entries
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    lkv_entry #(
      .RANK_W (RW),
      .THR_W  (OW)
    ) u_entry (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .sel    (target[i]),
      .thresh (thresh),
      .match  (match[i]),
      .valid  (valid[i]),
      .rank   (rank[i]),
      .value  (value[i])
    );
    // ranks of valid entries are 0..occupancy-1, so the oldest has the top one
    assign victim[i]    = valid[i] && (OW'(rank[i]) == occ_m1);
    // valid entries always fill from slot zero upwards
    assign free_slot[i] = (occupancy == OW'(i));
  end

  assign occ_m1 = occupancy - OW'(1);
  assign found  = |match;
  assign is_put = (s1_action == ACT_PUT);
  assign full   = (occupancy >= eff_cap);

  // keys are unique among valid entries, so at most one match to merge
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_rank = hit_rank | (rank[i] & {RW{match[i]}});
      hit_val  = hit_val | (value[i] & {VAL_W{match[i]}});
    end
  end

  // update command: the target becomes most recent, entries with a rank
  // below the threshold age by one
  always_comb begin
    cmd        = '0;
    cmd.key    = s1_key;
    cmd.value  = s1_val;
    target     = '0;
    thresh     = '0;
    insert     = 1'b0;
    if (proc) begin
      if (found) begin
        cmd.touch  = 1'b1;
        cmd.wr_val = is_put;
        target     = match;
        thresh     = OW'(hit_rank);
      end else if (is_put) begin
        cmd.touch  = 1'b1;
        cmd.wr_key = 1'b1;
        cmd.wr_val = 1'b1;
        if (full) begin
          // replace the least recent entry
          target = victim;
          thresh = occ_m1;
        end else begin
          // new entry in the next free slot, every valid entry ages
          target = free_slot;
          thresh = occupancy;
          insert = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (insert) begin
      occupancy <= occupancy + OW'(1);
    end
  end

  // result register
  always_comb begin
    if (is_put) begin
      res_val = PUT_VALUE;
    end else if (found) begin
      res_val = hit_val;
    end else begin
      res_val = MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      hit        <= found;
      read_value <= $signed(res_val);
    end
  end

  // checks
  `LKV_ASSERT_ALWAYS(a_unique_match, $onehot0(match), "more than one entry matched")
  `LKV_ASSERT_ALWAYS(a_occ_count, $countones(valid) == occupancy, "occupancy mismatch")
  `LKV_ASSERT_IMPL(a_one_victim, proc && is_put && !found && full, $onehot(victim), "no victim")
  `LKV_ASSERT_NEXT(a_insert_grows, insert, occupancy == $past(occupancy) + OW'(1), "no growth")
  `LKV_ASSERT_IMPL(a_stall_cause, !in_ready, s1_v && out_valid && !out_ready, "bad stall")

endmodule
